@@ hw/rtl/softmax_cross_entropy_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Softmax cross-entropy unit assertion macros
// Shared implication forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SOFTMAX_CROSS_ENTROPY_UNIT_DEFINES_SVH
`define SOFTMAX_CROSS_ENTROPY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SCE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle rule violated");

// Next-cycle implication, disabled while reset is high.
`define SCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle rule violated");

`endif

@@ hw/rtl/sce_pkg.sv @@
// ----------------------------------------------------------------------------
// Softmax cross-entropy package
// Constants and types shared by the softmax cross-entropy unit modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sce_pkg;

  // Default sizing.
  localparam int unsigned VEC_MAX_DEF        = 64;
  localparam int unsigned EXP_TABLE_BITS_DEF = 10;

  // Fixed-point constants.
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [26:0] VALUE_MAX = 27'd16777215;

  // Width of ln(S) in Q16.
  localparam int unsigned LNS_W = 19;

  // Output selection.
  typedef enum logic [1:0] {
    MODE_PROB  = 2'd0,
    MODE_DERIV = 2'd1,
    MODE_LOSS  = 2'd2,
    MODE_GRAD  = 2'd3
  } mode_t;

endpackage

@@ hw/rtl/sce_store.sv @@
// ----------------------------------------------------------------------------
// Element store
// Single-port-write, registered-read memory for the (logit, target) pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sce_store #(
  parameter int unsigned DEPTH = sce_pkg::VEC_MAX_DEF,
  parameter int unsigned WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/sce_exp.sv @@
// ----------------------------------------------------------------------------
// Exponential unit
// Two-stage pipeline giving exp(-m) in Q0.30 for a Q8.8 distance m >= 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sce_exp #(
  parameter int unsigned EXP_TABLE_BITS = sce_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [15:0] m,
  output logic        e_valid,
  output logic [30:0] e
);
  import sce_pkg::*;

  localparam int unsigned TSIZE = 1 << EXP_TABLE_BITS;

  typedef logic [30:0] exp_tab_t [TSIZE];

  // Integer square root, used only while the table is elaborated.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = '0;
    b   = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // Table of 2^-f in Q0.30, built from a chain of square roots of 2.
  function automatic exp_tab_t build_table();
    exp_tab_t    tab;
    logic [63:0] roots [EXP_TABLE_BITS+1];
    logic [63:0] v;
    roots[0] = 64'h1 << 29;
    for (int i = 1; i <= int'(EXP_TABLE_BITS); i++) begin
      roots[i] = isqrt64(roots[i-1] << 30);
    end
    for (int i = 0; i < int'(TSIZE); i++) begin
      v = 64'h1 << 30;
      for (int b = 0; b < int'(EXP_TABLE_BITS); b++) begin
        if (((i >> b) & 1) != 0) v = (v * roots[int'(EXP_TABLE_BITS) - b]) >> 30;
      end
      tab[i] = v[30:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_table();

  logic [32:0]               u_q;
  logic                      v1;
  logic [30:0]               rom_q;
  logic [8:0]                k_q;
  logic                      v2;

  // Valid tracking through the two stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // Stage one scales by log2(e); stage two reads the table.
  always_ff @(posedge clk) begin
    u_q   <= 33'(m) * 33'(LOG2E_Q16);
    rom_q <= EXP_TABLE[u_q[23 -: EXP_TABLE_BITS]];
    k_q   <= u_q[32:24];
  end

  // Integer part of the exponent becomes a right shift.
  assign e_valid = v2;
  assign e       = (k_q >= 9'd31) ? 31'd0 : (rom_q >> k_q[4:0]);

endmodule

@@ hw/rtl/sce_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division giving a 17-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sce_div #(
  parameter int unsigned SW = 37
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [SW+16:0] num,
  input  logic [SW-1:0]  den,
  output logic           done,
  output logic [16:0]    quot
);

  localparam int unsigned DW = SW + 17;

  logic          active;
  logic [4:0]    cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsh;

  // Control: count seventeen quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= 5'd17;
      end else if (active) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Datapath: compare against the shifted divisor and subtract.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= DW'(den) << 16;
      quot <= '0;
    end else if (active) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[15:0], 1'b1};
      end else begin
        quot <= {quot[15:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

@@ hw/rtl/sce_ln.sv @@
// ----------------------------------------------------------------------------
// Log unit
// Computes ln(S / 2^30) in Q16 by normalizing and repeated squaring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sce_ln #(
  parameter int unsigned SW = 37
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [SW-1:0]             s,
  output logic                      done,
  output logic [sce_pkg::LNS_W-1:0] lns
);
  import sce_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_SQ, L_MUL} lstate_t;

  lstate_t     state;
  logic [3:0]  cnt;
  logic [2:0]  nsh_q;
  logic [15:0] frac;
  logic [30:0] y;
  logic [2:0]  nsh;
  logic [61:0] sq;
  logic [31:0] y2;
  logic [34:0] lp;

  // Integer part of log2: position of the leading one above bit 30.
  always_comb begin
    nsh = '0;
    for (int b = 31; b < int'(SW); b++) begin
      if (s[b]) nsh = 3'(b - 30);
    end
  end

  assign sq = 62'(y) * 62'(y);
  assign y2 = sq[61:30];
  assign lp = 35'({nsh_q, frac}) * 35'(LN2_Q16);

  // Sequencer: sixteen squarings, then the scale by ln 2.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (start) begin
            cnt   <= '0;
            state <= L_SQ;
          end
        end
        L_SQ: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= L_MUL;
        end
        L_MUL: begin
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  // Mantissa and fraction bits.
  always_ff @(posedge clk) begin
    if (state == L_IDLE && start) begin
      nsh_q <= nsh;
      y     <= 31'(s >> nsh);
      frac  <= '0;
    end else if (state == L_SQ) begin
      if (y2[31]) begin
        y    <= y2[31:1];
        frac <= {frac[14:0], 1'b1};
      end else begin
        y    <= y2[30:0];
        frac <= {frac[14:0], 1'b0};
      end
    end
    if (state == L_MUL) begin
      lns <= lp[34:16];
    end
  end

endmodule

@@ hw/rtl/softmax_cross_entropy_unit.sv @@
// ----------------------------------------------------------------------------
// Softmax cross-entropy unit
// Loads (logit, target) pairs into memory, then emits softmax probability,
// derivative, cross-entropy loss or gradient for every stored element.
// ----------------------------------------------------------------------------
// Loading accepts one element per cycle while busy is low. The beat marked last
// raises busy: a sum pass reads the store once, the log unit runs, and each
// element is then emitted in turn, passing through the 17-step serial divider
// before the next one is read from the store. Results appear with
// result_valid for one cycle and cannot be stalled; the next vector may start
// in the cycle of the final result. Items beyond VEC_MAX are dropped and
// flagged through overflowed on every result of that vector. The mode register
// is sampled during the emit pass and is always ready.
`timescale 1ns / 1ps

module softmax_cross_entropy_unit #(
  parameter int unsigned VEC_MAX        = sce_pkg::VEC_MAX_DEF,
  parameter int unsigned EXP_TABLE_BITS = sce_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] logit,
  input  logic [16:0]        target,
  input  logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  output logic               result_valid,
  output logic signed [24:0] value,
  output logic [5:0]         element_index,
  output logic               end_of_vector,
  output logic               overflowed
);
  import sce_pkg::*;

  localparam int unsigned AW = $clog2(VEC_MAX);
  localparam int unsigned CW = $clog2(VEC_MAX + 1);
  localparam int unsigned SW = 31 + $clog2(VEC_MAX);
  localparam int unsigned DW = SW + 17;

  typedef enum logic [3:0] {
    S_LOAD, S_SUM, S_LN, S_E_RD, S_E_M, S_E_EXP, S_E_DIV, S_E_MUL, S_E_OUT
  } state_t;

  state_t             state;
  mode_t              mode;
  logic [CW-1:0]      element_count;
  logic signed [15:0] running_max;
  logic               overflow_flag;
  logic [CW-1:0]      rd_ptr;
  logic [CW-1:0]      acc_cnt;
  logic               rd_valid;
  logic               ln_start;
  logic               div_start;

  logic               accept;
  logic               we;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [32:0]        rdata;
  logic signed [16:0] diff;
  logic [15:0]        exp_m;
  logic               e_valid;
  logic [30:0]        e;
  logic               ln_done;
  logic [LNS_W-1:0]   lns;
  logic               div_done;
  logic [16:0]        quot;

  logic [SW-1:0]      s;
  logic [DW-1:0]      num_q;
  logic [15:0]        m_q;
  logic [16:0]        t_q;
  logic [16:0]        p_q;
  logic [41:0]        prod;
  logic [16:0]        mul_a;
  logic [24:0]        mul_b;
  logic [24:0]        nl;
  logic [42:0]        rnd;
  logic [26:0]        sh;
  logic [17:0]        grad;
  logic [24:0]        val;
  logic               is_end;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign we        = accept && (element_count < CW'(VEC_MAX));

  // Store read requests: a streaming sweep while summing, one read per element
  // while emitting.
  assign re    = ((state == S_SUM) && (rd_ptr < element_count)) || (state == S_E_RD);
  assign raddr = rd_ptr[AW-1:0];

  sce_store #(.DEPTH(VEC_MAX), .WIDTH(33)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (element_count[AW-1:0]),
    .wdata ({logit, target}),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Distance of each logit below the running maximum.
  assign diff  = {running_max[15], running_max} - {rdata[32], rdata[32:17]};
  assign exp_m = diff[15:0];

  sce_exp #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_exp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .m        (exp_m),
    .e_valid  (e_valid),
    .e        (e)
  );

  sce_ln #(.SW(SW)) u_ln (
    .clk   (clk),
    .rst   (rst),
    .start (ln_start),
    .s     (s),
    .done  (ln_done),
    .lns   (lns)
  );

  sce_div #(.SW(SW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_q),
    .den   (s),
    .done  (div_done),
    .quot  (quot)
  );

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PROB;
    end else if (cfg_valid && cfg_ready) begin
      mode <= mode_t'(cfg_data);
    end
  end

  // Shared multiplier operands: p(1-p) for the derivative, t * (-ln p) else.
  assign nl    = 25'({m_q, 8'd0}) + 25'(lns);
  assign mul_a = (mode == MODE_DERIV) ? p_q : t_q;
  assign mul_b = (mode == MODE_DERIV) ? 25'(ONE_Q16 - p_q) : nl;

  // Result selection with rounding and saturation.
  assign rnd  = 43'(prod) + 43'd32768;
  assign sh   = rnd[42:16];
  assign grad = {1'b0, p_q} - {1'b0, t_q};

  always_comb begin
    case (mode)
      MODE_PROB:  val = 25'(p_q);
      MODE_DERIV: val = sh[24:0];
      MODE_LOSS:  val = (sh > VALUE_MAX) ? VALUE_MAX[24:0] : sh[24:0];
      MODE_GRAD:  val = {{7{grad[17]}}, grad};
      default:    val = '0;
    endcase
  end

  assign is_end = (rd_ptr + CW'(1)) == element_count;

  // Sequencer: load, sum pass, log, then the emit pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      busy          <= 1'b0;
      result_valid  <= 1'b0;
      element_count <= '0;
      running_max   <= -16'sd32768;
      overflow_flag <= 1'b0;
      rd_ptr        <= '0;
      acc_cnt       <= '0;
      rd_valid      <= 1'b0;
      ln_start      <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      rd_valid     <= re;
      ln_start     <= 1'b0;
      div_start    <= 1'b0;
      result_valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (we) begin
              element_count <= element_count + CW'(1);
              if (logit > running_max) running_max <= logit;
            end else begin
              overflow_flag <= 1'b1;
            end
            if (last) begin
              busy    <= 1'b1;
              rd_ptr  <= '0;
              acc_cnt <= '0;
              state   <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (re) rd_ptr <= rd_ptr + CW'(1);
          if (e_valid) begin
            acc_cnt <= acc_cnt + CW'(1);
            if (acc_cnt + CW'(1) == element_count) begin
              ln_start <= 1'b1;
              state    <= S_LN;
            end
          end
        end
        S_LN: begin
          if (ln_done) begin
            rd_ptr <= '0;
            state  <= S_E_RD;
          end
        end
        S_E_RD:  state <= S_E_M;
        S_E_M:   state <= S_E_EXP;
        S_E_EXP: begin
          if (e_valid) begin
            div_start <= 1'b1;
            state     <= S_E_DIV;
          end
        end
        S_E_DIV: begin
          if (div_done) state <= S_E_MUL;
        end
        S_E_MUL: state <= S_E_OUT;
        S_E_OUT: begin
          result_valid <= 1'b1;
          if (is_end) begin
            busy          <= 1'b0;
            element_count <= '0;
            running_max   <= -16'sd32768;
            overflow_flag <= 1'b0;
            state         <= S_LOAD;
          end else begin
            rd_ptr <= rd_ptr + CW'(1);
            state  <= S_E_RD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      s <= '0;
    end else if (state == S_SUM && e_valid) begin
      s <= s + SW'(e);
    end
    if (state == S_E_M) begin
      m_q <= exp_m;
      t_q <= rdata[16:0];
    end
    if (state == S_E_EXP && e_valid) begin
      num_q <= (DW'(e) << 16) + DW'(s >> 1);
    end
    if (state == S_E_DIV && div_done) begin
      p_q <= quot;
    end
    if (state == S_E_MUL) begin
      prod <= 42'(mul_a) * 42'(mul_b);
    end
    if (state == S_E_OUT) begin
      value         <= val;
      element_index <= 6'(rd_ptr);
      end_of_vector <= is_end;
      overflowed    <= overflow_flag;
    end
  end

endmodule

@@ hw/rtl/sce_checker.sv @@
// ----------------------------------------------------------------------------
// Softmax cross-entropy port checker
// Watches the top-level ports for sequencing rules of the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "softmax_cross_entropy_unit_defines.svh"

module sce_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last,
  input logic result_valid,
  input logic end_of_vector
);

  // A result beat other than the final one only appears while busy.
  `SCE_ASSERT_NOW(a_mid_busy, clk, rst, result_valid && !end_of_vector, busy)

  // The final result beat releases the block.
  `SCE_ASSERT_NOW(a_end_free, clk, rst, result_valid && end_of_vector, !busy)

  // Result beats are never back to back.
  `SCE_ASSERT_NEXT(a_spaced, clk, rst, result_valid, !result_valid)

  // An accepted last beat starts the computation.
  `SCE_ASSERT_NEXT(a_last_busy, clk, rst, start && !busy && last, busy)

endmodule

bind softmax_cross_entropy_unit sce_checker u_sce_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .last          (last),
  .result_valid  (result_valid),
  .end_of_vector (end_of_vector)
);

@@ bench/softmax_cross_entropy_unit_test.sv @@
// ----------------------------------------------------------------------------
// Softmax cross-entropy unit testbench
// Loads directed and random vectors of (logit, target) pairs under every
// mode. A bit-exact predictor works out each element's result, and every
// result strobe is compared with the oldest pending expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module softmax_cross_entropy_unit_test;
  import sce_pkg::*;

  localparam int unsigned NMAX      = 64;
  localparam int unsigned TBITS     = 10;
  localparam int unsigned CYCLE_CAP = 600000;

  typedef struct {
    logic signed [24:0] value;
    logic [5:0]         index;
    logic               eov;
    logic               ovf;
  } result_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] logit;
    logic [16:0]        target;
    logic               last;
    logic               typed;
    logic signed [24:0] tval;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] logit = '0;
  logic [16:0]        target = '0;
  logic               last = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_data = '0;
  logic               result_valid;
  logic signed [24:0] value;
  logic [5:0]         element_index;
  logic               end_of_vector;
  logic               overflowed;

  softmax_cross_entropy_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .logit(logit), .target(target), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .value(value), .element_index(element_index),
    .end_of_vector(end_of_vector), .overflowed(overflowed)
  );

  // Shadow of the block: exp table, stored vector and mode.
  int unsigned        exp_lut [0:(1 << TBITS) - 1];
  logic signed [15:0] held_logit [0:NMAX-1];
  logic [16:0]        held_target [0:NMAX-1];
  int                 held_count;
  int                 peak_logit;
  bit                 dropped;
  mode_t              cur_mode;

  result_t pending_results[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      idle_enable = 1'b1;

  initial begin
    forever #10 clk = ~clk;
  end

  // Run guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Table of 2^-f in Q0.30 built from a chain of square roots of 2.
  task automatic build_exp_lut();
    longint unsigned roots [0:TBITS];
    longint unsigned v;
    roots[0] = 64'd1 << 29;
    for (int j = 1; j <= TBITS; j++) roots[j] = int_sqrt(roots[j-1] << 30);
    for (int i = 0; i < (1 << TBITS); i++) begin
      v = 64'd1 << 30;
      for (int b = 0; b < TBITS; b++)
        if ((i >> b) & 1) v = (v * roots[TBITS - b]) >> 30;
      exp_lut[i] = v[31:0];
    end
  endtask

  function automatic longint unsigned exp_of_gap(longint unsigned m);
    longint unsigned u, k, idx;
    u = m * 64'd94548;
    k = u >> 24;
    idx = (u & 64'hFFFFFF) >> (24 - TBITS);
    if (k >= 31) return 0;
    return longint'(exp_lut[idx]) >> k;
  endfunction

  // ln(S / 2^30) in Q16 by normalizing and repeated squaring.
  function automatic longint unsigned log_of_sum(longint unsigned s);
    longint unsigned y, frac, n;
    n = 0;
    frac = 0;
    while (n < 40 && (s >> n) >= (64'd1 << 31)) n++;
    y = s >> n;
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac <<= 1;
      if (y >= (64'd1 << 31)) begin
        frac |= 1;
        y >>= 1;
      end
    end
    return (((n << 16) | frac) * 64'd45426) >> 16;
  endfunction

  // Loads one element and, on the last mark, queues the whole vector's results.
  function automatic void softmax_predict(logic signed [15:0] x, logic [16:0] t,
                                          logic lst);
    longint unsigned s, lns, m, e, p, nl, loss;
    longint v;
    result_t r;
    if (held_count < NMAX) begin
      held_logit[held_count] = x;
      held_target[held_count] = t;
      held_count++;
      if (int'(x) > peak_logit) peak_logit = int'(x);
    end else begin
      dropped = 1'b1;
    end
    if (!lst) return;
    s = 0;
    for (int i = 0; i < held_count; i++)
      s += exp_of_gap(longint'(peak_logit - int'(held_logit[i])));
    if (s < (64'd1 << 30)) s = 64'd1 << 30;
    lns = log_of_sum(s);
    for (int i = 0; i < held_count; i++) begin
      m = longint'(peak_logit - int'(held_logit[i]));
      e = exp_of_gap(m);
      p = ((e << 16) + (s >> 1)) / s;
      case (cur_mode)
        MODE_PROB:  v = longint'(p);
        MODE_DERIV: v = longint'((p * (65536 - (p > 65536 ? 65536 : p)) + 32768) >> 16);
        MODE_LOSS: begin
          nl = (m << 8) + lns;
          loss = (longint'(held_target[i]) * nl + 32768) >> 16;
          v = loss > 16777215 ? 16777215 : longint'(loss);
        end
        default:    v = longint'(p) - longint'(held_target[i]);
      endcase
      if (v > 16777215) v = 16777215;
      if (v < -16777216) v = -16777216;
      r.value = v[24:0];
      r.index = i[5:0];
      r.eov = (i + 1 == held_count);
      r.ovf = dropped;
      pending_results = {pending_results, r};
    end
    held_count = 0;
    peak_logit = -32768;
    dropped = 1'b0;
  endfunction

  // Compare each result strobe with the oldest expectation.
  always @(negedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d index %0d", value, element_index);
      end else begin
        want = pending_results.pop_front();
        if (want.value !== value || want.index !== element_index ||
            want.eov !== end_of_vector || want.ovf !== overflowed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                     want.value, want.index, want.eov, want.ovf,
                     value, element_index, end_of_vector, overflowed);
        end
      end
    end
  end

  // One beat on the command port, with an optional random gap ahead of it.
  task automatic send_beat(logic signed [15:0] x, logic [16:0] t, logic lst);
    bit taken;
    if (idle_enable && $urandom_range(99) < 31) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    logit <= x;
    target <= t;
    last <= lst;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    softmax_predict(x, t, lst);
  endtask

  // Mode write, issued only while the block is idle.
  task automatic write_mode(mode_t md);
    bit taken;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= md;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    cur_mode = md;
  endtask

  function automatic logic signed [15:0] pick_logit(int centre, int spread);
    int x;
    x = centre + $urandom_range(2 * spread) - spread;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return x[15:0];
  endfunction

  function automatic logic [16:0] pick_target();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'd65536;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  row_t directed [0:15];

  initial begin
    int base, len, centre, spread, sent, vstart;
    directed = '{
      // Single element vectors: probability is exactly one.
      '{MODE_PROB,  16'sd0,      17'd0,     1'b1, 1'b1, 25'sd65536},
      '{MODE_DERIV, 16'sd100,    17'd40000, 1'b1, 1'b1, 25'sd0},
      '{MODE_LOSS,  -16'sd32768, 17'd65536, 1'b1, 1'b1, 25'sd0},
      '{MODE_GRAD,  16'sd32767,  17'd0,     1'b1, 1'b1, 25'sd65536},
      '{MODE_GRAD,  16'sd5,      17'd65536, 1'b1, 1'b1, 25'sd0},
      // Probability rounds to zero; the loss still follows from the gap.
      '{MODE_LOSS,  16'sd32767,  17'd0,     1'b0, 1'b1, 25'sd0},
      '{MODE_LOSS,  -16'sd32768, 17'd65536, 1'b1, 1'b1, 25'sd16776960},
      // Two equal logits split evenly.
      '{MODE_PROB,  -16'sd1,     17'd65535, 1'b0, 1'b1, 25'sd32768},
      '{MODE_PROB,  -16'sd1,     17'd43690, 1'b1, 1'b1, 25'sd32768},
      '{MODE_DERIV, 16'sd256,    17'd21845, 1'b0, 1'b0, 25'sd0},
      '{MODE_DERIV, -16'sd300,   17'd65536, 1'b0, 1'b0, 25'sd0},
      '{MODE_DERIV, 16'sd0,      17'd1,     1'b1, 1'b0, 25'sd0},
      '{MODE_GRAD,  16'sd1000,   17'd32768, 1'b0, 1'b0, 25'sd0},
      '{MODE_GRAD,  16'sd900,    17'd65536, 1'b1, 1'b0, 25'sd0},
      '{MODE_LOSS,  16'sd2000,   17'd12345, 1'b0, 1'b0, 25'sd0},
      '{MODE_LOSS,  16'sd1500,   17'd54321, 1'b1, 1'b0, 25'sd0}
    };
    build_exp_lut();
    held_count = 0;
    peak_logit = -32768;
    dropped = 1'b0;
    cur_mode = MODE_PROB;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; typed values replace the predicted ones.
    vstart = 0;
    for (int r = 0; r < 16; r++) begin
      if (held_count == 0 && mode_t'(directed[r].mode) != cur_mode)
        write_mode(mode_t'(directed[r].mode));
      if (held_count == 0) vstart = r;
      send_beat(directed[r].logit, directed[r].target, directed[r].last);
      // Once a vector closes, the queue holds exactly its results.
      if (directed[r].last) begin
        base = pending_results.size() - (r - vstart + 1);
        for (int k = vstart; k <= r; k++) begin
          if (directed[k].typed)
            pending_results[base + k - vstart].value = directed[k].tval;
        end
      end
    end

    // Random vectors.
    sent = 0;
    while (sent < 404) begin
      write_mode(mode_t'($urandom_range(3)));
      idle_enable = !(sent > 150 && sent < 250);
      case ($urandom_range(19))
        0:       len = 64 + $urandom_range(2);
        1, 2:    len = $urandom_range(21, 63);
        3, 4, 5, 6, 7: len = $urandom_range(7, 20);
        default: len = $urandom_range(1, 6);
      endcase
      centre = $urandom_range(65535) - 32768;
      spread = ($urandom_range(3) == 0) ? 32768 : $urandom_range(1, 1500);
      for (int i = 0; i < len; i++) begin
        if (len >= 64 && i == 0)
          send_beat(-16'sd32768, 17'd65536, 1'b0);
        else if (len >= 64 && i < 4)
          send_beat(16'sd32767, pick_target(), i == len - 1);
        else
          send_beat(pick_logit(centre, spread), pick_target(), i == len - 1);
      end
      sent += len;
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
